// ===== hdl/lfir_pkg.sv =====
// Shared constants, codes and the command type of the line FIR filter.
package lfir_pkg;

    localparam int MAX_RADIUS = 32;
    localparam int MAX_LINE   = 4096;
    localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
    localparam int ADD_DEPTH  = MAX_RADIUS + 1;

    localparam int TAP_W  = 18;
    localparam int SMP_W  = 24;
    localparam int PROD_W = TAP_W + SMP_W;
    localparam int ACC_W  = 50;
    localparam int POS_W  = 12;
    localparam int CNT_W  = 13;
    localparam int RAD_W  = 6;
    localparam int WPTR_W = 7;
    localparam int APTR_W = 6;
    localparam int K_W    = 7;
    localparam int OCNT_W = 6;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [0:0] {
        ACT_SAMPLE = 1'b0,
        ACT_TAP    = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        REG_RADIUS  = 2'd0,
        REG_REFLECT = 2'd1,
        REG_ADD_EN  = 2'd2
    } t_reg_idx;

    // One unit of work for the back end.
    typedef struct packed {
        logic                     is_tap;
        logic [K_W-1:0]           tap_index;
        logic signed [TAP_W-1:0]  tap_value;
        logic                     wr;        // store sample/addend
        logic signed [SMP_W-1:0]  smp;
        logic signed [SMP_W-1:0]  add;
        logic [WPTR_W-1:0]        wptr;      // window slot of sample n-1
        logic [APTR_W-1:0]        aptr;      // addend slot of sample n-1
        logic [CNT_W-1:0]         n;
        logic [POS_W-1:0]         xs;
        logic [OCNT_W-1:0]        cnt;
        logic [RAD_W-1:0]         rad;
        logic                     eol;
        logic                     ovf;
    } t_cmd;

endpackage

// ===== hdl/lfir_front.sv =====
// Front end: accepts input beats, tracks the line and issues commands.
module lfir_front import lfir_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_action,
    input  logic [IN_DATA_W-1:0]  i_data,
    input  logic                  i_last,
    output logic                  o_ready,
    input  logic [RAD_W-1:0]      i_radius,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [RAD_W-1:0]  r_lrad, n_lrad;
    logic              r_ovf, n_ovf;
    logic [WPTR_W-1:0] r_wnext, n_wnext, r_wlast, n_wlast;
    logic [APTR_W-1:0] r_anext, n_anext, r_alast, n_alast;

    logic              acc;
    logic [RAD_W-1:0]  lrad;
    logic [CNT_W-1:0]  lrad_x, nm1, first;
    t_cmd              cmd;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;
    assign o_cmd   = cmd;

    always_comb begin
        if (r_cnt == '0) begin
            lrad = (i_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : i_radius;
        end else begin
            lrad = r_lrad;
        end
        lrad_x = CNT_W'(lrad);

        cmd           = '0;
        cmd.tap_index = i_data[6:0];
        cmd.tap_value = i_data[24:7];
        cmd.smp       = i_data[48:25];
        cmd.add       = i_data[72:49];
        cmd.rad       = lrad;
        o_push        = 1'b0;
        nm1           = '0;
        first         = '0;

        n_cnt   = r_cnt;
        n_lrad  = r_lrad;
        n_ovf   = r_ovf;
        n_wnext = r_wnext;
        n_wlast = r_wlast;
        n_anext = r_anext;
        n_alast = r_alast;

        if (t_action'(i_action) == ACT_TAP) begin
            cmd.is_tap = 1'b1;
            o_push     = acc;
        end else if (r_cnt < CNT_W'(MAX_LINE)) begin
            cmd.wr   = 1'b1;
            cmd.wptr = r_wnext;
            cmd.aptr = r_anext;
            cmd.n    = r_cnt + 1'b1;
            o_push   = acc;
            if (acc) begin
                n_cnt   = r_cnt + 1'b1;
                n_lrad  = lrad;
                n_wlast = r_wnext;
                n_alast = r_anext;
                n_wnext = (r_wnext == WPTR_W'(WIN_DEPTH - 1)) ? '0 : r_wnext + 1'b1;
                n_anext = (r_anext == APTR_W'(ADD_DEPTH - 1)) ? '0 : r_anext + 1'b1;
            end
            nm1 = r_cnt;
        end else begin
            // line too long: sample dropped
            cmd.wptr = r_wlast;
            cmd.aptr = r_alast;
            cmd.n    = r_cnt;
            o_push   = acc && i_last;
            nm1      = r_cnt - 1'b1;
            if (acc) begin
                n_ovf = 1'b1;
            end
        end

        if (t_action'(i_action) == ACT_SAMPLE) begin
            first = (nm1 >= lrad_x) ? nm1 - lrad_x : '0;
            if (i_last) begin
                cmd.eol = 1'b1;
                cmd.ovf = n_ovf;
                cmd.xs  = POS_W'(first);
                cmd.cnt = OCNT_W'(cmd.n - first);
                if (acc) begin
                    n_cnt  = '0;
                    n_ovf  = 1'b0;
                    n_lrad = '0;
                end
            end else begin
                cmd.xs  = POS_W'(first);
                cmd.cnt = (nm1 >= lrad_x) ? OCNT_W'(1) : '0;
                cmd.ovf = r_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_lrad  <= '0;
            r_ovf   <= 1'b0;
            r_wnext <= '0;
            r_wlast <= '0;
            r_anext <= '0;
            r_alast <= '0;
        end else begin
            r_cnt   <= n_cnt;
            r_lrad  <= n_lrad;
            r_ovf   <= n_ovf;
            r_wnext <= n_wnext;
            r_wlast <= n_wlast;
            r_anext <= n_anext;
            r_alast <= n_alast;
        end
    end

endmodule

// ===== hdl/lfir_queue.sv =====
// Two-entry command queue between front and back end.
module lfir_queue import lfir_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// ===== hdl/lfir_back.sv =====
// Back end: tap/sample stores, multiply-accumulate loop, rounding and output register.
module lfir_back import lfir_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  t_cmd                   i_q_cmd,
    output logic                   o_q_pop,
    input  logic                   i_reflect,
    input  logic                   i_add_en,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [SMP_W-1:0] o_result,
    output logic [POS_W-1:0]       o_position,
    output logic                   o_saturated,
    output logic                   o_overflow,
    output logic                   o_last
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FIN   = 4'b1000
    } t_state;

    t_state r_state;
    t_cmd   r_cmd;
    logic [POS_W-1:0]  r_x;
    logic [OCNT_W-1:0] r_left;
    logic [K_W-1:0]    r_k, r_k0;
    logic [WPTR_W-1:0] r_d0;
    logic              r_v0, r_v1, r_v2;

    logic signed [TAP_W-1:0]  r_tap_mem [WIN_DEPTH];
    logic [WIN_DEPTH-1:0]     r_tap_vld;
    logic signed [SMP_W-1:0]  r_win_mem [WIN_DEPTH];
    logic signed [SMP_W-1:0]  r_add_mem [ADD_DEPTH];

    logic signed [TAP_W-1:0]  r_td;
    logic                     r_tv;
    logic signed [SMP_W-1:0]  r_wd, r_ad;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic signed [14:0] p, nm1s;
    logic [CNT_W-1:0]   nm1;
    logic [WPTR_W-1:0]  d0;
    logic [7:0]         waddr_t;
    logic [WPTR_W-1:0]  waddr;
    logic [APTR_W-1:0]  ad_d, aidx;
    logic [6:0]         aidx_t;
    logic [K_W-1:0]     kmax;

    logic signed [ACC_W-1:0]   tot, rv;
    logic signed [ACC_W-17:0]  q;
    logic signed [SMP_W-1:0]   res;
    logic                      sat, out_free, pop, tap_ok;

    assign out_free = !o_valid || i_ready;
    assign pop      = (r_state == ST_IDLE) && i_q_valid;
    assign o_q_pop  = pop;
    assign tap_ok   = (i_q_cmd.tap_index < K_W'(WIN_DEPTH));
    assign kmax     = {r_cmd.rad, 1'b0};
    assign nm1      = r_cmd.n - 1'b1;

    // edge padding of position x+k-R, expressed as distance back from sample n-1
    always_comb begin
        nm1s = 15'(nm1);
        p    = 15'(r_x) + 15'(r_k) - 15'(r_cmd.rad);
        if (i_reflect) begin
            if (p < 0) begin
                p = -p;
            end else if (p > nm1s) begin
                p = (nm1s <<< 1) - p;
            end
        end
        if (p < 0) begin
            p = '0;
        end
        if (p > nm1s) begin
            p = nm1s;
        end
        d0 = WPTR_W'(nm1s - p);
    end

    always_comb begin
        waddr_t = (r_cmd.wptr >= r_d0) ? 8'(r_cmd.wptr) - 8'(r_d0)
                                       : 8'(r_cmd.wptr) + 8'(WIN_DEPTH) - 8'(r_d0);
        waddr   = WPTR_W'(waddr_t);
        ad_d    = APTR_W'(nm1 - CNT_W'(r_x));
        aidx_t  = (r_cmd.aptr >= ad_d) ? 7'(r_cmd.aptr) - 7'(ad_d)
                                       : 7'(r_cmd.aptr) + 7'(ADD_DEPTH) - 7'(ad_d);
        aidx    = APTR_W'(aidx_t);
    end

    // round half up, then saturate
    always_comb begin
        tot = r_acc + (i_add_en ? (ACC_W'(r_ad) <<< 16) : '0);
        rv  = tot + ACC_W'(32768);
        q   = rv[ACC_W-1:16];
        sat = 1'b0;
        res = q[SMP_W-1:0];
        if (q > (ACC_W-16)'(8388607)) begin
            res = 24'sh7FFFFF;
            sat = 1'b1;
        end else if (q < -(ACC_W-16)'(8388608)) begin
            res = 24'sh800000;
            sat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_q_cmd.is_tap && tap_ok) begin
            r_tap_mem[i_q_cmd.tap_index] <= i_q_cmd.tap_value;
        end
        if (pop && !i_q_cmd.is_tap && i_q_cmd.wr) begin
            r_win_mem[i_q_cmd.wptr] <= i_q_cmd.smp;
            r_add_mem[i_q_cmd.aptr] <= i_q_cmd.add;
        end
        r_wd   <= r_win_mem[waddr];
        r_td   <= r_tap_mem[r_k0];
        r_ad   <= r_add_mem[aidx];
        r_tv   <= r_tap_vld[r_k0];
        r_d0   <= d0;
        r_k0   <= r_k;
        r_prod <= (r_tv ? r_td : $signed(TAP_W'(0))) * r_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_tap_vld <= '0;
            r_v0      <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_v0 <= (r_state == ST_MAC);
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (pop) begin
                        r_cmd <= i_q_cmd;
                        if (i_q_cmd.is_tap) begin
                            if (tap_ok) begin
                                r_tap_vld[i_q_cmd.tap_index] <= 1'b1;
                            end
                        end else if (i_q_cmd.cnt != '0) begin
                            r_x     <= i_q_cmd.xs;
                            r_left  <= i_q_cmd.cnt;
                            r_k     <= '0;
                            r_acc   <= '0;
                            r_state <= ST_MAC;
                        end
                    end
                end
                ST_MAC: begin
                    if (r_k == kmax) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (!r_v0 && !r_v1 && !r_v2) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        o_valid     <= 1'b1;
                        o_result    <= res;
                        o_position  <= r_x;
                        o_saturated <= sat;
                        o_overflow  <= r_cmd.ovf;
                        o_last      <= r_cmd.eol && (CNT_W'(r_x) == nm1);
                        if (r_left > OCNT_W'(1)) begin
                            r_x     <= r_x + 1'b1;
                            r_left  <= r_left - 1'b1;
                            r_k     <= '0;
                            r_acc   <= '0;
                            r_state <= ST_MAC;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/line_fir_filter_with_edge_padding_top.sv =====
// Top level of the line FIR filter with edge padding.
//
//  channel   direction  beat holds
//  s_axis    in         tap load or sample (tuser = action, tlast = end of line)
//  m_axis    out        filtered pixel (tuser = flags, tlast = last of line)
//  cfg       in         register index and value
//
// Each output sums 2*R+1 taps on the single multiply-accumulate unit, then
// the pipeline drains and the sum is rounded; tap beats and samples that
// produce no output skip the MAC loop. A line end drains up to R+1 outputs in
// a row. Reset is synchronous; the front keeps taking beats into the queue,
// up to its two entries, while the back end stalls on m_axis_tready.
module line_fir_filter_with_edge_padding_top import lfir_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [6:0] tap_index, [24:7] tap_value, [48:25] sample, [72:49] addend
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] action
    input  logic [0:0]            s_axis_tuser,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [23:0] result, [35:24] position
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] saturated, [1] overflow
    output logic [1:0]            m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [RAD_W-1:0]      i_cfg_data
);

    logic [RAD_W-1:0] r_radius;
    logic             r_reflect, r_add_en;

    logic push, q_full, q_valid, q_pop;
    t_cmd push_cmd, q_cmd;
    logic signed [SMP_W-1:0] result;
    logic [POS_W-1:0]        position;
    logic                    sat, ovf;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= RAD_W'(2);
            r_reflect <= 1'b0;
            r_add_en  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_RADIUS:  r_radius  <= i_cfg_data;
                REG_REFLECT: r_reflect <= i_cfg_data[0];
                REG_ADD_EN:  r_add_en  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    lfir_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_action (s_axis_tuser[0]),
        .i_data   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_ready  (s_axis_tready),
        .i_radius (r_radius),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    lfir_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    lfir_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .i_reflect   (r_reflect),
        .i_add_en    (r_add_en),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (result),
        .o_position  (position),
        .o_saturated (sat),
        .o_overflow  (ovf),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, position, result};
    assign m_axis_tuser = {ovf, sat};

endmodule
